// ===== rtl/core/rdlm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the level threshold table of the RMS level meter.
package rdlm_pkg;

    localparam int MAX_BLOCK_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_W           = 13;
    localparam int RESET_BLOCK_LEN = 512;
    localparam int LEVEL_W         = 7;
    localparam int NUM_LEVELS      = 101;
    localparam int THRESH_W        = 41;
    localparam int THRESH_FRAC     = 40;
    localparam int QUEUE_DEPTH     = 2;

    typedef logic [NUM_LEVELS-1:0][THRESH_W-1:0] t_thresh_tab;

    // T[k] = round(10^(0.06k - 6) * 2^40), built once at elaboration.
    function automatic t_thresh_tab build_thresh();
        t_thresh_tab tab;
        real         r;
        for (int k = 0; k < NUM_LEVELS; k++) begin
            r      = $pow(10.0, (6.0 * k - 600.0) / 100.0) * (2.0 ** THRESH_FRAC);
            tab[k] = THRESH_W'(longint'(r));
        end
        return tab;
    endfunction

    localparam t_thresh_tab THRESH = build_thresh();

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_CMP,
        S_DONE
    } t_srch_state;

    typedef struct packed {
        logic pop;
        logic ld_prod;
        logic step;
        logic ld_out;
    } t_srch_ctl;

endpackage

// ===== rtl/core/rdlm_front.sv =====
`timescale 1ns / 1ps
// Front end: block length register, sample squaring and block accumulation.
module rdlm_front #(
    parameter int SAMPLE_BITS = rdlm_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_BLOCK   = rdlm_pkg::MAX_BLOCK_DEF,
    localparam int SQ_W  = 2 * SAMPLE_BITS - 1,
    localparam int SUM_W = SQ_W + $clog2(MAX_BLOCK),
    localparam int CNT_W = $clog2(MAX_BLOCK + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr,
    input  logic [rdlm_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_sample_valid,
    output logic                           o_sample_stall,
    input  logic signed [SAMPLE_BITS-1:0]  i_sample,
    input  logic                           i_q_full,
    output logic                           o_push,
    output logic [SUM_W-1:0]               o_sum,
    output logic [CNT_W-1:0]               o_len
);

    localparam int RST_LEN = (rdlm_pkg::RESET_BLOCK_LEN > MAX_BLOCK) ?
                             MAX_BLOCK : rdlm_pkg::RESET_BLOCK_LEN;

    logic [SUM_W-1:0]               r_sum;
    logic [SUM_W-1:0]               n_sum;
    logic [CNT_W-1:0]               r_count;
    logic [CNT_W-1:0]               r_blk_len;
    logic [CNT_W-1:0]               w_cfg_len;
    logic signed [2*SAMPLE_BITS-1:0] w_sq_full;
    logic                           w_last;
    logic                           w_accept;

    // Clamp the written length into 1..MAX_BLOCK.
    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_len = CNT_W'(1);
        end else if (int'(i_cfg_data) > MAX_BLOCK) begin
            w_cfg_len = CNT_W'(MAX_BLOCK);
        end else begin
            w_cfg_len = CNT_W'(i_cfg_data);
        end
    end

    assign w_sq_full      = i_sample * i_sample;
    assign n_sum          = r_sum + SUM_W'(w_sq_full[SQ_W-1:0]);
    assign w_last         = (r_count == r_blk_len - CNT_W'(1));
    assign o_sample_stall = w_last && i_q_full;
    assign w_accept       = i_sample_valid && !o_sample_stall;

    assign o_push = w_accept && w_last;
    assign o_sum  = n_sum;
    assign o_len  = r_blk_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_len <= CNT_W'(RST_LEN);
            r_sum     <= '0;
            r_count   <= '0;
        end else if (i_cfg_wr) begin
            r_blk_len <= w_cfg_len;
            r_sum     <= '0;
            r_count   <= '0;
        end else if (w_accept) begin
            if (w_last) begin
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= n_sum;
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/rdlm_queue.sv =====
`timescale 1ns / 1ps
// Short request queue between the accumulator and the level search.
module rdlm_queue #(
    parameter int DATA_W = 56
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_data
);

    localparam int DEPTH = rdlm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_cnt;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/rdlm_search.sv =====
`timescale 1ns / 1ps
// Back end: binary search of the level over the threshold table, output register.
module rdlm_search #(
    parameter int SAMPLE_BITS = rdlm_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_BLOCK   = rdlm_pkg::MAX_BLOCK_DEF,
    localparam int SUM_W = 2 * SAMPLE_BITS - 1 + $clog2(MAX_BLOCK),
    localparam int CNT_W = $clog2(MAX_BLOCK + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  logic [SUM_W-1:0]             i_sum,
    input  logic [CNT_W-1:0]             i_len,
    output logic                         o_pop,
    output logic                         o_level_valid,
    input  logic                         i_level_stall,
    output logic [rdlm_pkg::LEVEL_W-1:0] o_level
);

    localparam int LW     = rdlm_pkg::LEVEL_W;
    localparam int SHIFT  = rdlm_pkg::THRESH_FRAC + 2 - 2 * SAMPLE_BITS;
    localparam int LSH    = (SHIFT >= 0) ? SHIFT : 0;
    localparam int RSH    = (SHIFT < 0) ? -SHIFT : 0;
    localparam int PROD_W = rdlm_pkg::THRESH_W + CNT_W;
    localparam int LHS_W  = SUM_W + LSH;
    localparam int RHS_W  = PROD_W + RSH;
    localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    rdlm_pkg::t_srch_state r_state;
    rdlm_pkg::t_srch_state n_state;
    rdlm_pkg::t_srch_ctl   w_ctl;

    logic [CMP_W-1:0]  r_lhs;
    logic [PROD_W-1:0] r_prod;
    logic [CNT_W-1:0]  r_len;
    logic [LW-1:0]     r_lo;
    logic [LW-1:0]     r_hi;
    logic [LW-1:0]     n_lo;
    logic [LW-1:0]     n_hi;
    logic [LW-1:0]     w_mid;
    logic              w_pass;
    logic              w_done;
    logic              w_out_free;
    logic              r_out_valid;
    logic [LW-1:0]     r_level;

    assign w_mid      = LW'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    assign w_pass     = (r_lhs >= (CMP_W'(r_prod) << RSH));
    assign n_lo       = w_pass ? w_mid : r_lo;
    assign n_hi       = w_pass ? r_hi : w_mid;
    assign w_done     = ((n_hi - n_lo) == LW'(1));
    assign w_out_free = !r_out_valid || !i_level_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rdlm_pkg::S_IDLE: begin
                if (!i_empty) n_state = rdlm_pkg::S_MUL;
            end
            rdlm_pkg::S_MUL: begin
                n_state = rdlm_pkg::S_CMP;
            end
            rdlm_pkg::S_CMP: begin
                n_state = w_done ? rdlm_pkg::S_DONE : rdlm_pkg::S_MUL;
            end
            rdlm_pkg::S_DONE: begin
                if (w_out_free) n_state = rdlm_pkg::S_IDLE;
            end
            default: begin
                n_state = rdlm_pkg::S_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb begin
        w_ctl = '0;
        case (r_state)
            rdlm_pkg::S_IDLE: w_ctl.pop     = !i_empty;
            rdlm_pkg::S_MUL:  w_ctl.ld_prod = 1'b1;
            rdlm_pkg::S_CMP:  w_ctl.step    = 1'b1;
            rdlm_pkg::S_DONE: w_ctl.ld_out  = w_out_free;
            default:          w_ctl         = '0;
        endcase
    end

    assign o_pop = w_ctl.pop;

    always_ff @(posedge i_clk) begin
        if (w_ctl.pop) begin
            r_lhs <= CMP_W'(i_sum) << LSH;
            r_len <= i_len;
            r_lo  <= '0;
            r_hi  <= LW'(rdlm_pkg::NUM_LEVELS);
        end
        if (w_ctl.ld_prod) begin
            r_prod <= PROD_W'(rdlm_pkg::THRESH[w_mid]) * PROD_W'(r_len);
        end
        if (w_ctl.step) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (w_ctl.ld_out) begin
            r_level <= r_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rdlm_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctl.ld_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_level_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_level_valid = r_out_valid;
    assign o_level       = r_level;

endmodule

// ===== rtl/core/rms_db_level_meter_unit.sv =====
`timescale 1ns / 1ps
// Top level of the block RMS loudness meter with a 0..100 decibel scale.
//
// Signed Q1.15 samples enter on the sample channel, one per cycle. Each is
// squared and added into a running sum; when block-length samples have
// arrived, the sum and the block length are handed to a two-entry request
// queue and the sum restarts at zero with no gap. The back end pops one
// request and finds the level: the largest k in 0..100 with
// sum * 2^10 >= T[k] * block_length, T[k] = round(10^(0.06k - 6) * 2^40),
// i.e. floor((20*log10(rms) + 60) * 100 / 60) clamped, with full scale 1.0.
// An all-zero block gives 0. The search is a binary search of six or seven
// steps over the constant threshold table; each step reads the table and
// multiplies by the block length (S_MUL), then compares (S_CMP); a level
// also takes a pop before the search and an output load after it.
// Samples flow at one per cycle as long as blocks hold at least 16 samples;
// with shorter blocks the sample channel stalls on the last sample of a block
// while the queue is full. The level leaves through an output register; a
// stalled consumer holds the search unit in its final state once the next
// level is ready, and the sample channel stalls only when the queue is also
// full at the end of a block. The config port is always ready. Writing
// block_length (1..MAX_BLOCK; 0 reads as 1, larger as MAX_BLOCK) restarts the
// current block; the user writes it only while the meter is idle (unenforced).
module rms_db_level_meter_unit #(
    parameter int SAMPLE_BITS = rdlm_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_BLOCK   = rdlm_pkg::MAX_BLOCK_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [rdlm_pkg::CFG_W-1:0]   i_cfg_data,
    // sample channel
    input  logic                         i_sample_valid,
    output logic                         o_sample_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    // level channel
    output logic                         o_level_valid,
    input  logic                         i_level_stall,
    output logic [rdlm_pkg::LEVEL_W-1:0] o_level
);

    localparam int SUM_W = 2 * SAMPLE_BITS - 1 + $clog2(MAX_BLOCK);
    localparam int CNT_W = $clog2(MAX_BLOCK + 1);
    localparam int REQ_W = SUM_W + CNT_W;

    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_empty;
    logic [SUM_W-1:0] w_sum;
    logic [CNT_W-1:0] w_len;
    logic [REQ_W-1:0] w_q_out;

    // The user makes register writes only while idle (not enforced); accept them at once.
    assign o_cfg_ready = 1'b1;

    // Accumulate squares and cut blocks.
    rdlm_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_BLOCK   (MAX_BLOCK)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_sample_valid (i_sample_valid),
        .o_sample_stall (o_sample_stall),
        .i_sample       (i_sample),
        .i_q_full       (w_full),
        .o_push         (w_push),
        .o_sum          (w_sum),
        .o_len          (w_len)
    );

    // Hold finished blocks until the search unit is free.
    rdlm_queue #(
        .DATA_W (REQ_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_sum, w_len}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_q_out)
    );

    // Search the level and drive the output register.
    rdlm_search #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_BLOCK   (MAX_BLOCK)
    ) u_search (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_sum         (w_q_out[REQ_W-1:CNT_W]),
        .i_len         (w_q_out[CNT_W-1:0]),
        .o_pop         (w_pop),
        .o_level_valid (o_level_valid),
        .i_level_stall (i_level_stall),
        .o_level       (o_level)
    );

endmodule

// ===== rtl/core/rdlm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the RMS level meter and their binding to the top level.
module rdlm_checker #(
    parameter int SAMPLE_BITS = rdlm_pkg::SAMPLE_BITS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_cfg_valid,
    input logic                         o_cfg_ready,
    input logic                         i_sample_valid,
    input logic                         o_sample_stall,
    input logic [SAMPLE_BITS-1:0]       i_sample,
    input logic                         o_level_valid,
    input logic                         i_level_stall,
    input logic [rdlm_pkg::LEVEL_W-1:0] o_level
);

    // Nothing is pending right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_level_valid)
        else $error("level valid right after reset");

    // Levels stay within the scale.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_level_valid |-> (o_level <= rdlm_pkg::LEVEL_W'(rdlm_pkg::NUM_LEVELS - 1)))
        else $error("level above 100");

    // A register write restarts the block and never yields a level.
    a_cfg_no_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> !$rose(o_level_valid))
        else $error("level produced by a register write");

    // A stalled level holds.
    a_level_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_level_valid && i_level_stall) |=> (o_level_valid && $stable(o_level)))
        else $error("stalled level dropped or changed");

    // A stalled sample request holds.
    a_sample_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample_valid && o_sample_stall) |=> (i_sample_valid && $stable(i_sample)))
        else $error("stalled sample dropped or changed");

endmodule

bind rms_db_level_meter_unit rdlm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_rdlm_checker (.*);
